// ----- rtl/core/vad_pkg.sv -----
// ----------------------------------------------------------------------------
// vad_pkg
// Shared types, constants and the arctangent table of the vector angle block.
// ----------------------------------------------------------------------------
`default_nettype none

package vad_pkg;

  localparam int unsigned ANGLE_FRAC = 24;   // fraction bits of the CORDIC angle
  localparam int unsigned NORM_W     = 30;   // normalized operand width
  localparam int unsigned XY_W       = 34;   // CORDIC x/y datapath width
  localparam int unsigned Z_W        = 33;   // CORDIC angle accumulator width
  localparam int unsigned OUT_W      = 24;   // result width
  localparam int unsigned TABLE_LEN  = 32;

  typedef struct packed {
    logic valid;
    logic dot_neg;
    logic degen;
  } vad_side_t;

  // atan(2^-i) in degrees, Q.24, rounded to nearest
  function automatic logic [29:0] atan_deg(input int unsigned idx);
    logic [29:0] v;
    unique case (idx)
      0:  v = 30'd754974720;
      1:  v = 30'd445687602;
      2:  v = 30'd235489088;
      3:  v = 30'd119537938;
      4:  v = 30'd60000934;
      5:  v = 30'd30029717;
      6:  v = 30'd15018523;
      7:  v = 30'd7509720;
      8:  v = 30'd3754917;
      9:  v = 30'd1877466;
      10: v = 30'd938734;
      11: v = 30'd469367;
      12: v = 30'd234684;
      13: v = 30'd117342;
      14: v = 30'd58671;
      15: v = 30'd29335;
      16: v = 30'd14668;
      17: v = 30'd7334;
      18: v = 30'd3667;
      19: v = 30'd1833;
      20: v = 30'd917;
      21: v = 30'd458;
      22: v = 30'd229;
      23: v = 30'd115;
      24: v = 30'd57;
      25: v = 30'd29;
      26: v = 30'd14;
      27: v = 30'd7;
      28: v = 30'd4;
      29: v = 30'd2;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vad_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// vad_cordic_stage
// One registered vectoring CORDIC iteration; side info travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module vad_cordic_stage #(
  parameter int unsigned IDX = 0
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  en_i,
  input  wire logic signed [vad_pkg::XY_W-1:0] x_i,
  input  wire logic signed [vad_pkg::XY_W-1:0] y_i,
  input  wire logic signed [vad_pkg::Z_W-1:0]  z_i,
  input  wire vad_pkg::vad_side_t              side_i,
  output logic signed [vad_pkg::XY_W-1:0]      x_o,
  output logic signed [vad_pkg::XY_W-1:0]      y_o,
  output logic signed [vad_pkg::Z_W-1:0]       z_o,
  output vad_pkg::vad_side_t                   side_o
);

  localparam logic signed [vad_pkg::Z_W-1:0] ATAN =
    vad_pkg::Z_W'(vad_pkg::atan_deg(IDX));

  logic signed [vad_pkg::XY_W-1:0] x_d, y_d, xs, ys;
  logic signed [vad_pkg::Z_W-1:0]  z_d;
  logic                            ypos;
  logic                            valid_q;
  logic [1:0]                      flags_q;

  assign xs   = x_i >>> IDX;
  assign ys   = y_i >>> IDX;
  assign ypos = !y_i[vad_pkg::XY_W-1] && (y_i != '0);

  always_comb begin
    if (ypos) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o     <= x_d;
      y_o     <= y_d;
      z_o     <= z_d;
      flags_q <= {side_i.dot_neg, side_i.degen};
    end
  end

  assign side_o.valid   = valid_q;
  assign side_o.dot_neg = flags_q[1];
  assign side_o.degen   = flags_q[0];

endmodule

`default_nettype wire

// ----- rtl/core/vector2_angle_degrees_top.sv -----
// ----------------------------------------------------------------------------
// vector2_angle_degrees_top
// Unsigned angle between two 2-D vectors, degrees, via pipelined CORDIC.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o carry one vector pair per transfer
// (four signed fixed-point components). Output channel: out_valid_o/
// out_ready_i carry the angle (Q(24-FRACTION_BITS).FRACTION_BITS degrees, 0 to 180) and the
// degenerate flag, set when either vector is zero (angle then exactly 90).
// Pipeline registers in order: component magnitudes, products, dot/cross
// sums, leading-one search, normalizing shift, the CORDIC iterations,
// quadrant fold, then rounding into the output register.
// Throughput is one pair per cycle; the whole pipeline advances together.
// When the receiver stalls with a result held, the pipeline freezes and
// in_ready_o drops; nothing is lost or repeated. Reset clears all valid
// bits, so the pipeline comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module vector2_angle_degrees_top #(
  parameter int unsigned COMPONENT_WIDTH = 32,
  parameter int unsigned FRACTION_BITS   = 16,
  parameter int unsigned CORDIC_STAGES   = 24
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [COMPONENT_WIDTH-1:0]  first_x_i,
  input  wire logic [COMPONENT_WIDTH-1:0]  first_y_i,
  input  wire logic [COMPONENT_WIDTH-1:0]  second_x_i,
  input  wire logic [COMPONENT_WIDTH-1:0]  second_y_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [vad_pkg::OUT_W-1:0]        angle_deg_o,
  output logic                             degenerate_o
);

  localparam int unsigned CW   = COMPONENT_WIDTH;
  localparam int unsigned W2   = 2 * CW;
  localparam int unsigned PW   = $clog2(W2 + 1);
  localparam int unsigned NS   = (CORDIC_STAGES > vad_pkg::TABLE_LEN) ?
                                 vad_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int unsigned NW   = vad_pkg::NORM_W;
  localparam int unsigned XYW  = vad_pkg::XY_W;
  localparam int unsigned ZW   = vad_pkg::Z_W;
  localparam int unsigned RSH  = vad_pkg::ANGLE_FRAC - FRACTION_BITS;
  localparam logic [33:0] HALF = (34'd1 << RSH) >> 1;
  localparam logic [33:0] LIM  = 34'd180 << FRACTION_BITS;
  localparam logic [33:0] DEG90_OUT = 34'd90 << FRACTION_BITS;
  localparam logic signed [ZW-1:0] Z90  = ZW'(90) <<< vad_pkg::ANGLE_FRAC;
  localparam logic [ZW-1:0]        Z180 = ZW'(180) << vad_pkg::ANGLE_FRAC;

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: sign and magnitude
  logic          s1_v_q, s1_degen_q;
  logic [3:0]    s1_neg_q;
  logic [CW-1:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;

  function automatic logic [CW-1:0] mag_of(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + CW'(1)) : v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ax_q    <= mag_of(first_x_i);
      s1_ay_q    <= mag_of(first_y_i);
      s1_bx_q    <= mag_of(second_x_i);
      s1_by_q    <= mag_of(second_y_i);
      s1_neg_q   <= {first_x_i[CW-1], first_y_i[CW-1], second_x_i[CW-1], second_y_i[CW-1]};
      s1_degen_q <= ((first_x_i == '0) && (first_y_i == '0)) ||
                    ((second_x_i == '0) && (second_y_i == '0));
    end
  end

  // stage 2: products
  logic          s2_v_q, s2_degen_q;
  logic [3:0]    s2_neg_q;
  logic [W2-1:0] s2_axbx_q, s2_ayby_q, s2_axby_q, s2_aybx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_axbx_q  <= W2'(s1_ax_q) * W2'(s1_bx_q);
      s2_ayby_q  <= W2'(s1_ay_q) * W2'(s1_by_q);
      s2_axby_q  <= W2'(s1_ax_q) * W2'(s1_by_q);
      s2_aybx_q  <= W2'(s1_ay_q) * W2'(s1_bx_q);
      s2_neg_q   <= {s1_neg_q[3] ^ s1_neg_q[1], s1_neg_q[2] ^ s1_neg_q[0],
                     s1_neg_q[3] ^ s1_neg_q[0], s1_neg_q[2] ^ s1_neg_q[1]};
      s2_degen_q <= s1_degen_q;
    end
  end

  // stage 3: dot and cross
  logic signed [W2:0] t_axbx, t_ayby, t_axby, t_aybx, dot_s, cross_s;
  logic          s3_v_q, s3_degen_q, s3_neg_q;
  logic [W2-1:0] s3_dot_q, s3_cross_q;

  always_comb begin
    t_axbx  = s2_neg_q[3] ? -$signed({1'b0, s2_axbx_q}) : $signed({1'b0, s2_axbx_q});
    t_ayby  = s2_neg_q[2] ? -$signed({1'b0, s2_ayby_q}) : $signed({1'b0, s2_ayby_q});
    t_axby  = s2_neg_q[1] ? -$signed({1'b0, s2_axby_q}) : $signed({1'b0, s2_axby_q});
    t_aybx  = s2_neg_q[0] ? -$signed({1'b0, s2_aybx_q}) : $signed({1'b0, s2_aybx_q});
    dot_s   = t_axbx + t_ayby;
    cross_s = t_axby - t_aybx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_dot_q   <= dot_s[W2] ? W2'(-dot_s) : W2'(dot_s);
      s3_cross_q <= cross_s[W2] ? W2'(-cross_s) : W2'(cross_s);
      s3_neg_q   <= dot_s[W2];
      s3_degen_q <= s2_degen_q;
    end
  end

  // stage 4: leading-one position of the larger operand
  logic [W2-1:0] orv;
  logic [PW-1:0] lead;
  logic          s4_v_q, s4_degen_q, s4_neg_q;
  logic [W2-1:0] s4_dot_q, s4_cross_q;
  logic [PW-1:0] s4_sh_q;

  assign orv = s3_dot_q | s3_cross_q;

  always_comb begin
    lead = '0;
    for (int k = 0; k < W2; k++) begin
      if (orv[k]) begin
        lead = PW'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (adv) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_dot_q   <= s3_dot_q;
      s4_cross_q <= s3_cross_q;
      s4_sh_q    <= lead + PW'(1);
      s4_neg_q   <= s3_neg_q;
      s4_degen_q <= s3_degen_q;
    end
  end

  // stage 5: normalize so the larger operand lies in [2^29, 2^30)
  logic [W2+NW-1:0] dot_ext, cross_ext;
  logic [XYW-1:0]   c0_x, c0_y;
  vad_pkg::vad_side_t c0_side;

  logic signed [XYW-1:0] cx [0:NS];
  logic signed [XYW-1:0] cy [0:NS];
  logic signed [ZW-1:0]  cz [0:NS];
  vad_pkg::vad_side_t    cside [0:NS];

  assign dot_ext   = {s4_dot_q, NW'(0)} >> s4_sh_q;
  assign cross_ext = {s4_cross_q, NW'(0)} >> s4_sh_q;
  assign c0_x      = XYW'(dot_ext[NW-1:0]);
  assign c0_y      = XYW'(cross_ext[NW-1:0]);
  assign c0_side   = '{valid: s4_v_q, dot_neg: s4_neg_q, degen: s4_degen_q};

  logic s5_v_q, s5_neg_q, s5_degen_q;
  logic signed [XYW-1:0] s5_x_q, s5_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (adv) begin
      s5_v_q <= c0_side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_x_q     <= $signed(c0_x);
      s5_y_q     <= $signed(c0_y);
      s5_neg_q   <= c0_side.dot_neg;
      s5_degen_q <= c0_side.degen;
    end
  end

  assign cx[0]          = s5_x_q;
  assign cy[0]          = s5_y_q;
  assign cz[0]          = '0;
  assign cside[0].valid   = s5_v_q;
  assign cside[0].dot_neg = s5_neg_q;
  assign cside[0].degen   = s5_degen_q;

  // CORDIC iterations
  for (genvar g = 0; g < NS; g++) begin : g_cordic
    vad_cordic_stage #(.IDX(g)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .x_i    (cx[g]),
      .y_i    (cy[g]),
      .z_i    (cz[g]),
      .side_i (cside[g]),
      .x_o    (cx[g+1]),
      .y_o    (cy[g+1]),
      .z_o    (cz[g+1]),
      .side_o (cside[g+1])
    );
  end

  // fold: clamp to [0, 90], mirror for negative dot product
  logic signed [ZW-1:0] zc;
  logic [ZW-1:0]        zf;
  logic                 f_v_q, f_degen_q;
  logic [ZW-1:0]        f_z_q;

  always_comb begin
    if (cz[NS][ZW-1]) begin
      zc = '0;
    end else if (cz[NS] > Z90) begin
      zc = Z90;
    end else begin
      zc = cz[NS];
    end
    zf = cside[NS].dot_neg ? (Z180 - ZW'(zc)) : ZW'(zc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (adv) begin
      f_v_q <= cside[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_z_q     <= zf;
      f_degen_q <= cside[NS].degen;
    end
  end

  // round half up, saturate, output register
  logic [33:0] rsum, rres, rsat;

  assign rsum = 34'(f_z_q) + HALF;
  assign rres = rsum >> RSH;
  assign rsat = (rres > LIM) ? LIM : rres;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_deg_o  <= f_degen_q ? DEG90_OUT[vad_pkg::OUT_W-1:0] : rsat[vad_pkg::OUT_W-1:0];
      degenerate_o <= f_degen_q;
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_vector2_angle_degrees_top.sv -----
// ----------------------------------------------------------------------------
// tb_vector2_angle_degrees_top
// Checks the vector angle block against a bit-exact predictor of its CORDIC
// arithmetic, with random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vector2_angle_degrees_top;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int NSTG = 24;
  localparam int AF = 24;
  localparam int N_RAND = 1950;
  localparam int HOLD_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [23:0] angle;
    logic        degen;
  } angle_res_t;

  function automatic angle_res_t predict_angle(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                               logic [CW-1:0] bx, logic [CW-1:0] by);
    angle_res_t r;
    longint signed dot, crs, xa, ya, xn, z;
    logic [63:0] c, d, m;
    logic [63:0] res;
    logic        dneg;
    int          tbl [32];
    tbl = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
            15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
            58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
            14, 7, 4, 2, 1, 0};
    if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
      r.angle = 24'(90 << FB);
      r.degen = 1'b1;
      return r;
    end
    // exact products fit in 65 bits signed; use 128-bit to be safe
    begin
      logic signed [127:0] dd, cc;
      dd = 128'($signed(ax)) * $signed(bx) + 128'($signed(ay)) * $signed(by);
      cc = 128'($signed(ax)) * $signed(by) - 128'($signed(ay)) * $signed(bx);
      dneg = dd < 0;
      d = 64'(dd < 0 ? -dd : dd);
      c = 64'(cc < 0 ? -cc : cc);
    end
    m = (c > d) ? c : d;
    while (m >= 64'(1) << 30) begin m >>= 1; c >>= 1; d >>= 1; end
    while (m < 64'(1) << 29) begin m <<= 1; c <<= 1; d <<= 1; end
    xa = d;
    ya = c;
    z = 0;
    for (int i = 0; i < NSTG; i++) begin
      if (ya > 0) begin
        xn = xa + (ya >>> i);
        ya = ya - (xa >>> i);
        z += tbl[i];
      end else begin
        xn = xa - (ya >>> i);
        ya = ya + (xa >>> i);
        z -= tbl[i];
      end
      xa = xn;
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << AF)) z = longint'(90) << AF;
    if (dneg) z = (longint'(180) << AF) - z;
    res = (64'(z) + (64'(1) << (AF - FB - 1))) >> (AF - FB);
    if (res > (64'(180) << FB)) res = 64'(180) << FB;
    r.angle = res[23:0];
    r.degen = 1'b0;
    return r;
  endfunction

  class angle_scoreboard;
    angle_res_t pending[$];
    int errors;

    function void note_pair(logic [CW-1:0] ax, logic [CW-1:0] ay,
                            logic [CW-1:0] bx, logic [CW-1:0] by);
      pending.push_back(predict_angle(ax, ay, bx, by));
    endfunction

    task check_result(logic [23:0] angle, logic degen);
      angle_res_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result angle=%0h", angle));
        return;
      end
      e = pending.pop_front();
      if (angle !== e.angle)
        report_mismatch($sformatf("angle got %0h exp %0h", angle, e.angle));
      if (degen !== e.degen)
        report_mismatch($sformatf("degenerate got %0b exp %0b", degen, e.degen));
    endtask

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CW-1:0] first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [23:0] angle_deg_o;
  logic degenerate_o;

  angle_scoreboard sb = new();
  longint cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  bit hold_go = 1'b0;
  bit stim_done = 1'b0;

  vector2_angle_degrees_top #(
    .COMPONENT_WIDTH(CW), .FRACTION_BITS(FB), .CORDIC_STAGES(NSTG)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .first_x_i(first_x_i), .first_y_i(first_y_i),
    .second_x_i(second_x_i), .second_y_i(second_y_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .angle_deg_o(angle_deg_o), .degenerate_o(degenerate_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // long receiver hold-off, timed in cycles
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(angle_deg_o, degenerate_o);
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 37);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_pair(first_x_i, first_y_i, second_x_i, second_y_i);
  end

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return CW'($signed($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pair(logic [CW-1:0] ax, logic [CW-1:0] ay,
                           logic [CW-1:0] bx, logic [CW-1:0] by);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_x_i <= ax;
    first_y_i <= ay;
    second_x_i <= bx;
    second_y_i <= by;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin
    logic [CW-1:0] ax, ay;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed corners
    send_pair('0, '0, 32'h0001_0000, '0);
    send_pair(32'h0001_0000, '0, '0, '0);
    send_pair('0, '0, '0, '0);
    send_pair(32'h0001_0000, '0, 32'h0001_0000, '0);
    send_pair(32'h0001_0000, '0, 32'hffff_0000, '0);
    send_pair(32'h0001_0000, '0, '0, 32'h0001_0000);
    send_pair(32'h0001_0000, '0, '0, 32'hffff_0000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(32'h0000_0001, '0, 32'h0000_0001, 32'h0000_0001);
    send_pair(32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 32'hffff_fffe);
    send_pair(32'h7fff_ffff, 32'h0000_0001, 32'h7fff_ffff, '0);
    send_pair(32'hffff_ffff, '0, 32'h0000_0001, '0);
    send_pair(32'h0003_0000, 32'h0004_0000, 32'hfffc_0000, 32'h0003_0000);
    send_pair(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 300) hold_go = 1'b1;
      calm = (i >= 800 && i < 1100);
      ax = rand_comp();
      ay = rand_comp();
      case ($urandom_range(3))
        0: send_pair(ax, ay, ax, ay);
        1: send_pair(ax, ay, -ay, ax);
        2: send_pair(ax, ay, -ax, -ay);
        default: send_pair(ax, ay, rand_comp(), rand_comp());
      endcase
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (NSTG + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/vad_pkg.sv
rtl/core/vad_cordic_stage.sv
rtl/core/vector2_angle_degrees_top.sv
bench/tb_vector2_angle_degrees_top.sv
